@@ design/fspc_pkg.sv @@
`timescale 1ns / 1ps
// shared types, decode constants and reset values for the five stage pipeline core
// no dependencies
package fspc_pkg;

  localparam int MEM_BYTES = 1024;
  localparam int REG_COUNT = 32;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int RF_AW     = $clog2(REG_COUNT);
  localparam int OUT_AW    = 10;

  // opcodes and r-type functions
  localparam logic [5:0] OP_RTYPE  = 6'h00;
  localparam logic [5:0] OP_LB     = 6'h20;
  localparam logic [5:0] OP_SB     = 6'h28;
  localparam logic [5:0] FUNCT_ADD = 6'h20;
  localparam logic [5:0] FUNCT_SUB = 6'h22;

  localparam logic [31:0] RF_RESET_BASE = 32'h0000_0100;

  // decode to execute
  typedef struct packed {
    logic             regwrite;
    logic             memread;
    logic             memwrite;
    logic             memtoreg;
    logic             rtype;
    logic [31:0]      a;
    logic [31:0]      b;
    logic [15:0]      offset;
    logic [5:0]       funct;
    logic [RF_AW-1:0] rt;
    logic [RF_AW-1:0] rd;
  } dx_t;

  // execute to memory
  typedef struct packed {
    logic             regwrite;
    logic             memread;
    logic             memwrite;
    logic             memtoreg;
    logic [31:0]      alu;
    logic [31:0]      store_val;
    logic [RF_AW-1:0] wreg;
  } xm_t;

  // memory to writeback
  typedef struct packed {
    logic             regwrite;
    logic             memtoreg;
    logic [7:0]       loaded;
    logic [31:0]      alu;
    logic [RF_AW-1:0] wreg;
  } mw_t;

  // one reported result
  typedef struct packed {
    logic              rw_valid;
    logic [RF_AW-1:0]  rw_index;
    logic [31:0]       rw_value;
    logic              mw_valid;
    logic [OUT_AW-1:0] mw_addr;
    logic [7:0]        mw_byte;
    logic              oob;
  } res_t;

  // register file contents before the first write
  function automatic logic [31:0] rf_reset_value(input logic [RF_AW-1:0] idx);
    logic [31:0] val;
    val = (idx == '0) ? 32'h0 : (RF_RESET_BASE + 32'(idx));
    return val;
  endfunction

endpackage

@@ design/five_stage_pipeline_core_unit.sv @@
`timescale 1ns / 1ps
// five stage pipeline core: fetch, decode, execute, memory, writeback
// register file and data memory held in synchronous arrays; uses fspc_pkg
//
// usage
//   input channel: one instruction word per request (in_valid_i / in_stall_o)
//   output channel: one result per request (out_valid_o / out_stall_i), giving
//   the writeback register write and the memory stage store of that step
//   every accepted instruction advances all five stages by one; a register
//   write shows up four requests after its instruction, a store three after
//   each result is registered in the output register, or in the skid entry
//   while the output register is held; throughput: one request per cycle
//   while in_stall_o is low; the limit is the read-modify-write of the two
//   memories, whose reads are issued at the accept that precedes use
//   reset: latches clear to bubbles, the register file reads its reset values
//   through per-entry valid bits, and a clearing pass over all MEM_BYTES
//   (1024) addresses writes address modulo 256 into the data memory;
//   in_stall_o is high during that pass
//   receiver stall: a two-entry output buffer (register plus skid) keeps
//   taking requests until both entries are full, then raises in_stall_o
module five_stage_pipeline_core_unit
  import fspc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       instruction_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              reg_write_valid_o,
  output logic [RF_AW-1:0]  reg_write_index_o,
  output logic [31:0]       reg_write_value_o,
  output logic              mem_write_valid_o,
  output logic [OUT_AW-1:0] mem_write_address_o,
  output logic [7:0]        mem_write_byte_o,
  output logic              out_of_bounds_o
);

  // memories
  logic [31:0] rf_mem [REG_COUNT];
  logic [7:0]  dm_mem [MEM_BYTES];

  // pipeline latches
  logic [31:0] fd_q;
  dx_t         dx_q, dx_d;
  xm_t         xm_q, xm_d;
  mw_t         mw_q, mw_d;

  // register file read side
  logic [REG_COUNT-1:0] rf_vld_q;
  logic [31:0]          rf_rdata_a_q, rf_rdata_b_q;
  logic                 a_fwd_q, b_fwd_q, a_init_q, b_init_q;
  logic [RF_AW-1:0]     a_idx_q, b_idx_q;
  logic [31:0]          fwd_val_q;
  logic [31:0]          rf_a, rf_b;

  // data memory side
  logic [7:0]        dm_rdata_q;
  logic              dm_fwd_q;
  logic [7:0]        dm_fwd_byte_q;
  logic              clearing_q;
  logic [MEM_AW-1:0] clr_addr_q;

  // output buffer
  res_t res;
  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;

  logic             accept, pop;
  logic [5:0]       op;
  logic [RF_AW-1:0] rs_next, rt_next;
  logic             wb_we;
  logic [RF_AW-1:0] wb_idx;
  logic [31:0]      wb_val;
  logic             xm_in_range, store_en;
  logic [MEM_AW-1:0] dm_raddr, dm_waddr;
  logic [7:0]       dm_wdata, dm_byte;
  logic             dm_we;

  assign in_stall_o = skid_valid_q | clearing_q;
  assign accept     = in_valid_i & ~in_stall_o;
  assign pop        = out_valid_q & ~out_stall_i;

  // operands as seen by decode: forwarded writeback, reset value or array data
  assign rf_a = a_fwd_q ? fwd_val_q : (a_init_q ? rf_reset_value(a_idx_q) : rf_rdata_a_q);
  assign rf_b = b_fwd_q ? fwd_val_q : (b_init_q ? rf_reset_value(b_idx_q) : rf_rdata_b_q);

  // decode stage
  assign op = fd_q[31:26];
  always_comb begin
    dx_d = '0;
    if (fd_q != 32'h0 && (op == OP_RTYPE || op == OP_LB || op == OP_SB)) begin
      dx_d.a      = rf_a;
      dx_d.b      = rf_b;
      dx_d.rt     = fd_q[20:16];
      dx_d.rd     = fd_q[15:11];
      dx_d.offset = fd_q[15:0];
      dx_d.funct  = fd_q[5:0];
      if (op == OP_RTYPE) begin
        dx_d.rtype    = 1'b1;
        dx_d.regwrite = 1'b1;
      end else if (op == OP_LB) begin
        dx_d.memread  = 1'b1;
        dx_d.memtoreg = 1'b1;
        dx_d.regwrite = 1'b1;
      end else begin
        dx_d.memwrite = 1'b1;
      end
    end
  end

  // execute stage
  always_comb begin
    xm_d.regwrite  = dx_q.regwrite;
    xm_d.memread   = dx_q.memread;
    xm_d.memwrite  = dx_q.memwrite;
    xm_d.memtoreg  = dx_q.memtoreg;
    xm_d.store_val = dx_q.b;
    if (dx_q.rtype) begin
      if (dx_q.funct == FUNCT_ADD) begin
        xm_d.alu = dx_q.a + dx_q.b;
      end else if (dx_q.funct == FUNCT_SUB) begin
        xm_d.alu = dx_q.a - dx_q.b;
      end else begin
        xm_d.alu = 32'h0;
      end
      xm_d.wreg = dx_q.rd;
    end else begin
      xm_d.alu  = dx_q.a + {16'h0, dx_q.offset};
      xm_d.wreg = dx_q.rt;
    end
  end

  // memory stage
  assign xm_in_range = xm_q.alu < 32'(MEM_BYTES);
  assign store_en    = xm_q.memwrite & ~xm_q.memread & xm_in_range;
  assign dm_byte     = dm_fwd_q ? dm_fwd_byte_q : dm_rdata_q;

  always_comb begin
    mw_d          = '0;
    mw_d.regwrite = xm_q.regwrite;
    mw_d.memtoreg = xm_q.memtoreg;
    mw_d.alu      = xm_q.alu;
    if (xm_q.memread) begin
      if (xm_in_range) begin
        mw_d.loaded = dm_byte;
        mw_d.wreg   = xm_q.wreg;
      end
    end else if (!xm_q.memwrite && xm_q.regwrite) begin
      mw_d.wreg = xm_q.wreg;
    end
  end

  // writeback stage
  assign wb_idx = mw_q.wreg;
  assign wb_val = mw_q.memtoreg ? {24'h0, mw_q.loaded} : mw_q.alu;
  assign wb_we  = accept & mw_q.regwrite & (wb_idx != '0);

  // result of this step
  always_comb begin
    res = '0;
    if (mw_q.regwrite) begin
      res.rw_valid = 1'b1;
      res.rw_index = wb_idx;
      res.rw_value = wb_val;
    end
    if (store_en) begin
      res.mw_valid = 1'b1;
      res.mw_addr  = xm_q.alu[OUT_AW-1:0];
      res.mw_byte  = xm_q.store_val[7:0];
    end
    res.oob = (xm_q.memread | xm_q.memwrite) & ~xm_in_range;
  end

  // read addresses for the next step
  assign rs_next  = instruction_i[25:21];
  assign rt_next  = instruction_i[20:16];
  assign dm_raddr = xm_d.alu[MEM_AW-1:0];

  // data memory write port shared with the clearing pass
  assign dm_we    = clearing_q | (accept & store_en);
  assign dm_waddr = clearing_q ? clr_addr_q : xm_q.alu[MEM_AW-1:0];
  assign dm_wdata = clearing_q ? clr_addr_q[7:0] : xm_q.store_val[7:0];

  // register file array
  always_ff @(posedge clk_i) begin
    if (wb_we) begin
      rf_mem[wb_idx] <= wb_val;
    end
    if (accept) begin
      rf_rdata_a_q <= rf_mem[rs_next];
      rf_rdata_b_q <= rf_mem[rt_next];
    end
  end

  // data memory array
  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dm_mem[dm_waddr] <= dm_wdata;
    end
    if (accept) begin
      dm_rdata_q <= dm_mem[dm_raddr];
    end
  end

  // pipeline latches, forwarding and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_q          <= '0;
      dx_q          <= '0;
      xm_q          <= '0;
      mw_q          <= '0;
      rf_vld_q      <= '0;
      a_fwd_q       <= 1'b0;
      b_fwd_q       <= 1'b0;
      a_init_q      <= 1'b1;
      b_init_q      <= 1'b1;
      a_idx_q       <= '0;
      b_idx_q       <= '0;
      fwd_val_q     <= '0;
      dm_fwd_q      <= 1'b0;
      dm_fwd_byte_q <= '0;
    end else if (accept) begin
      fd_q      <= instruction_i;
      dx_q      <= dx_d;
      xm_q      <= xm_d;
      mw_q      <= mw_d;
      if (wb_we) begin
        rf_vld_q[wb_idx] <= 1'b1;
      end
      // a write in this step lands in the same edge as the read: forward it
      a_fwd_q   <= wb_we & (wb_idx == rs_next);
      b_fwd_q   <= wb_we & (wb_idx == rt_next);
      a_init_q  <= ~rf_vld_q[rs_next];
      b_init_q  <= ~rf_vld_q[rt_next];
      a_idx_q   <= rs_next;
      b_idx_q   <= rt_next;
      fwd_val_q <= wb_val;
      dm_fwd_q      <= store_en & (xm_q.alu[MEM_AW-1:0] == dm_raddr);
      dm_fwd_byte_q <= xm_q.store_val[7:0];
    end
  end

  // data memory clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      if (clr_addr_q == MEM_AW'(MEM_BYTES - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else begin
      if (!out_valid_q || pop) begin
        if (skid_valid_q) begin
          out_q        <= skid_q;
          out_valid_q  <= 1'b1;
          skid_valid_q <= accept;
          if (accept) begin
            skid_q <= res;
          end
        end else begin
          out_valid_q <= accept;
          if (accept) begin
            out_q <= res;
          end
        end
      end else if (accept) begin
        skid_q       <= res;
        skid_valid_q <= 1'b1;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign reg_write_valid_o   = out_q.rw_valid;
  assign reg_write_index_o   = out_q.rw_index;
  assign reg_write_value_o   = out_q.rw_value;
  assign mem_write_valid_o   = out_q.mw_valid;
  assign mem_write_address_o = out_q.mw_addr;
  assign mem_write_byte_o    = out_q.mw_byte;
  assign out_of_bounds_o     = out_q.oob;

endmodule
